// File: rtl/pip_pkg.sv
package pip_pkg;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_DROPPED = 2'd2;

  typedef struct packed {
    logic clear;
    logic append;
    logic load;
    logic rd;
    logic wrap;
    logic report;
  } pip_cmd_t;

  typedef struct packed {
    logic empty;
    logic last;
  } pip_stat_t;

endpackage

// File: rtl/pip_ctrl.sv
module pip_ctrl
  import pip_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] cmd,
  input  pip_stat_t  stat,
  output pip_cmd_t   ctl,
  output logic       busy
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_WRAP   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_REPORT = 3'd4;

  localparam logic [1:0] DRAIN_LAST = 2'd2;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [1:0] drain_cnt;
  logic [1:0] drain_cnt_next;
  logic       accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && (state == S_IDLE);

  always_comb begin
    state_next     = state;
    drain_cnt_next = drain_cnt;
    ctl            = '0;
    unique case (state)
      S_IDLE: begin
        ctl.clear  = accept && (cmd == CMD_CLEAR);
        ctl.append = accept && (cmd == CMD_APPEND);
        ctl.load   = accept && (cmd == CMD_QUERY);
        if (ctl.load) begin
          state_next = stat.empty ? S_REPORT : S_READ;
        end
      end
      S_READ: begin
        ctl.rd = 1'b1;
        if (stat.last) begin
          state_next = S_WRAP;
        end
      end
      S_WRAP: begin
        ctl.wrap       = 1'b1;
        drain_cnt_next = '0;
        state_next     = S_DRAIN;
      end
      S_DRAIN: begin
        drain_cnt_next = drain_cnt + 2'd1;
        if (drain_cnt == DRAIN_LAST) begin
          state_next = S_REPORT;
        end
      end
      S_REPORT: begin
        ctl.report = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      drain_cnt <= '0;
    end else begin
      state     <= state_next;
      drain_cnt <= drain_cnt_next;
    end
  end

endmodule

// File: rtl/pip_dp.sv
module pip_dp
  import pip_pkg::*;
#(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  pip_cmd_t                     ctl,
  input  logic signed [COORD_BITS-1:0] x_coord,
  input  logic signed [COORD_BITS-1:0] y_coord,
  output pip_stat_t                    stat,
  output logic                         done,
  output logic                         is_inside,
  output logic [1:0]                   status
);

  localparam int AW  = $clog2(MAX_VERTICES);
  localparam int CW  = $clog2(MAX_VERTICES + 1);
  localparam int DW  = COORD_BITS + 1;
  localparam int PW  = 2 * DW;

  logic signed [COORD_BITS-1:0] mem_x [MAX_VERTICES];
  logic signed [COORD_BITS-1:0] mem_y [MAX_VERTICES];

  logic [CW-1:0] count;
  logic [CW-1:0] count_m1;
  logic          overflow;
  logic          full;
  logic [AW-1:0] rd_addr;

  logic signed [COORD_BITS-1:0] px, py;
  logic signed [COORD_BITS-1:0] q_x, q_y;
  logic signed [COORD_BITS-1:0] prev_x, prev_y;
  logic signed [COORD_BITS-1:0] first_x, first_y;

  logic rd_d, first_d, wrap_d;

  logic                         s0_valid;
  logic                         s0_edge;
  logic signed [COORD_BITS-1:0] cur_x, cur_y;
  logic signed [COORD_BITS-1:0] ax, ay, bx, by, xmax;
  logic                         in_span, x_ok;

  logic                 s1_valid, s1_cand, s1_vert;
  logic signed [DW-1:0] s1_dx1, s1_dy, s1_dy2, s1_dx2;

  logic                 s2_valid, s2_cand, s2_vert;
  logic signed [PW-1:0] prod_l, prod_r;

  logic parity;

  assign full       = (count == CW'(MAX_VERTICES));
  assign count_m1   = count - CW'(1);
  assign stat.empty = (count == '0);
  assign stat.last  = (rd_addr == count_m1[AW-1:0]);

  // vertex store
  always_ff @(posedge clk) begin
    if (ctl.append && !full) begin
      mem_x[count[AW-1:0]] <= x_coord;
      mem_y[count[AW-1:0]] <= y_coord;
    end
    if (ctl.rd) begin
      q_x <= mem_x[rd_addr];
      q_y <= mem_y[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      overflow <= 1'b0;
    end else if (ctl.clear) begin
      count    <= '0;
      overflow <= 1'b0;
    end else if (ctl.append) begin
      if (full) begin
        overflow <= 1'b1;
      end else begin
        count <= count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_addr <= '0;
    end else if (ctl.load) begin
      rd_addr <= '0;
    end else if (ctl.rd) begin
      rd_addr <= rd_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      px <= x_coord;
      py <= y_coord;
    end
  end

  // edge walk: previous vertex against the one just read, then the wrap edge
  assign s0_valid = rd_d || wrap_d;
  assign s0_edge  = s0_valid && !first_d;
  assign cur_x    = wrap_d ? first_x : q_x;
  assign cur_y    = wrap_d ? first_y : q_y;

  always_comb begin
    if (prev_y <= cur_y) begin
      ax = prev_x; ay = prev_y; bx = cur_x; by = cur_y;
    end else begin
      ax = cur_x; ay = cur_y; bx = prev_x; by = prev_y;
    end
    xmax    = (prev_x > cur_x) ? prev_x : cur_x;
    in_span = (py > ay) && (py <= by);
    x_ok    = (px <= xmax);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_d     <= 1'b0;
      first_d  <= 1'b0;
      wrap_d   <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      rd_d     <= ctl.rd;
      first_d  <= ctl.rd && (rd_addr == '0);
      wrap_d   <= ctl.wrap;
      s1_valid <= s0_edge;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_valid) begin
      prev_x <= cur_x;
      prev_y <= cur_y;
    end
    if (first_d) begin
      first_x <= q_x;
      first_y <= q_y;
    end
    s1_cand <= in_span && x_ok;
    s1_vert <= (prev_x == cur_x);
    s1_dx1  <= DW'(px) - DW'(ax);
    s1_dy   <= DW'(by) - DW'(ay);
    s1_dy2  <= DW'(py) - DW'(ay);
    s1_dx2  <= DW'(bx) - DW'(ax);
    s2_cand <= s1_cand;
    s2_vert <= s1_vert;
    prod_l  <= PW'(s1_dx1) * PW'(s1_dy);
    prod_r  <= PW'(s1_dy2) * PW'(s1_dx2);
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      parity <= 1'b0;
    end else if (s2_valid && s2_cand && (s2_vert || (prod_l <= prod_r))) begin
      parity <= ~parity;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.report;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.report) begin
      is_inside <= stat.empty ? 1'b0 : parity;
      if (stat.empty) begin
        status <= ST_EMPTY;
      end else if (overflow) begin
        status <= ST_DROPPED;
      end else begin
        status <= ST_OK;
      end
    end
  end

endmodule

// File: rtl/point_in_polygon_test.sv
// Even-odd point-in-polygon test. A beat is taken when start is high and busy is
// low; cmd clears the vertex list, appends (x_coord, y_coord) as the next vertex,
// or queries that point. Clear and append finish in the cycle they are taken and
// give no result, so busy stays low. A query answers with a one-cycle done strobe
// carrying is_inside and status, which the receiver cannot stall. The query walks
// the stored vertices through a single read port of the vertex memory, one edge
// per cycle, then the closing edge, then a three-stage compare pipeline. done is
// registered from the report state and rises as busy falls. An empty list skips
// the walk and answers with status empty. Appends past MAX_VERTICES are dropped
// and later queries report status dropped until a clear.
module point_in_polygon_test
  import pip_pkg::*;
#(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   cmd,
  input  logic signed [COORD_BITS-1:0] x_coord,
  input  logic signed [COORD_BITS-1:0] y_coord,
  output logic                         done,
  output logic                         is_inside,
  output logic [1:0]                   status
);

  pip_cmd_t  ctl;
  pip_stat_t stat;

  pip_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy)
  );

  pip_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .x_coord   (x_coord),
    .y_coord   (y_coord),
    .stat      (stat),
    .done      (done),
    .is_inside (is_inside),
    .status    (status)
  );

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result beat while busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result beat repeated");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd == CMD_QUERY) |=> busy)
    else $error("query taken without going busy");

  a_empty_out: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_EMPTY) |-> !is_inside)
    else $error("empty polygon reported inside");

endmodule
